>>> hdl/cap_pkg.sv
// Shared types and constants for the capability revocation tree.
// Holds default sizes, request codes, node state codes and sequencer states.
// No dependencies.
package cap_pkg;

	localparam int NODES_DEF      = 1024;
	localparam int COUNT_BITS_DEF = 16;

	// Request codes on the action field
	typedef enum logic [2:0] {
		ACT_ALLOC  = 3'd0,
		ACT_SPLIT  = 3'd1,
		ACT_REFCNT = 3'd2,
		ACT_NONLIN = 3'd3,
		ACT_REVOKE = 3'd4,
		ACT_DROP   = 3'd5
	} act_t;

	// Node state codes
	localparam logic [1:0] NS_FREE    = 2'd0;
	localparam logic [1:0] NS_VALID   = 2'd1;
	localparam logic [1:0] NS_INVALID = 2'd2;

	// Link field patched by a read-modify-write
	typedef enum logic [1:0] {
		LF_PRV,
		LF_NXT,
		LF_FCH
	} lnk_fld_t;

	typedef enum logic [4:0] {
		S_IDLE,
		S_CHK,
		S_TAKE,
		S_TAKE_W,
		S_NEW,
		S_AFCH,
		S_SID,
		S_LNK_RD,
		S_LNK_WR,
		S_DROP0,
		S_DROP1,
		S_DWALK,
		S_DWALK_W,
		S_DROP2,
		S_DROPN,
		S_FIN_RD,
		S_FIN_WR,
		S_RPUSH,
		S_RPUSH_W,
		S_RPOP,
		S_RPOP_W,
		S_RNODE,
		S_RTF,
		S_RFIN_RD,
		S_RFIN_WR,
		S_DONE
	} state_t;

endpackage

>>> hdl/cap_ram.sv
// Simple dual-port RAM: one write port, one read port with registered data.
// Used for the node pool and the walk stack. No package dependency.
module cap_ram #(
	parameter int DEPTH = 1024,
	parameter int WIDTH = 8,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		rdata <= mem[raddr];
	end

endmodule

>>> hdl/cap_sat_add.sv
// Saturating reference count adder: count plus signed delta, clamped to
// zero and to the all-ones count. Combinational; no package dependency.
module cap_sat_add #(
	parameter int COUNT_BITS = 16
) (
	input  logic [COUNT_BITS-1:0] cnt,
	input  logic signed [8:0]     delta,
	output logic [COUNT_BITS-1:0] sum
);

	localparam int SW = ((COUNT_BITS > 9) ? COUNT_BITS : 9) + 2;

	logic signed [SW-1:0] s;
	logic signed [SW-1:0] smax;

	assign smax = $signed(SW'({COUNT_BITS{1'b1}}));
	assign s    = $signed(SW'(cnt)) + SW'(delta);

	always_comb begin
		if (s < 0) begin
			sum = '0;
		end else if (s > smax) begin
			sum = {COUNT_BITS{1'b1}};
		end else begin
			sum = s[COUNT_BITS-1:0];
		end
	end

endmodule

>>> hdl/capability_revocation_tree.sv
// Capability revocation tree: node pool, free list and subtree walker.
// Depends on cap_pkg, cap_ram (node pool, walk stack) and cap_sat_add.
//
//   channel | direction | handshake            | payload
//   --------+-----------+----------------------+------------------------------
//   in      | to block  | in_valid / in_ready  | action, node_id, delta
//   out     | from block| out_valid / out_ready| new_id, granted, nonlinear_only
//
// Sequence: every request is accepted in S_IDLE, its target record is read for
// S_CHK and the result is handed off from S_DONE. Refcount and set-nonlinear
// add nothing more; allocate and split then take a free or bumped node, write
// it and patch the links. Revoke walks the subtree through the walk stack, and
// drop relinks the node's children into its place before invalidating it; all
// of these are serialised by the one read port of the node pool.
// Reset: arst_n clears control, free list head (null) and bump pointer; the
// pool needs no clearing pass. Stalls: in_ready is high only between
// requests; a finished result is held in the output register until taken.
module capability_revocation_tree #(
	parameter int NODES      = cap_pkg::NODES_DEF,
	parameter int COUNT_BITS = cap_pkg::COUNT_BITS_DEF,
	localparam int ID_W      = $clog2(NODES + 1)
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  logic [2:0]        action,
	input  logic [ID_W-1:0]   node_id,
	input  logic signed [8:0] delta,
	output logic              out_valid,
	input  logic              out_ready,
	output logic [ID_W-1:0]   new_id,
	output logic              granted,
	output logic              nonlinear_only
);

	import cap_pkg::*;

	localparam int IDX_W = (NODES > 1) ? $clog2(NODES) : 1;
	localparam logic [ID_W-1:0] NIL = ID_W'(NODES);

	typedef struct packed {
		logic [1:0]            st;
		logic                  nl;
		logic [COUNT_BITS-1:0] rc;
		logic [ID_W-1:0]       par;
		logic [ID_W-1:0]       prv;
		logic [ID_W-1:0]       nxt;
		logic [ID_W-1:0]       fch;
	} node_t;

	state_t state_q, state_d;

	// Control registers
	logic [ID_W-1:0] free_q, free_d;
	logic [ID_W-1:0] bump_q, bump_d;
	logic [ID_W-1:0] depth_q, depth_d;
	logic            out_valid_q, out_valid_d;

	// Working registers
	act_t                  act_q, act_d;
	logic [ID_W-1:0]       id_q, id_d;
	logic signed [8:0]     delta_q, delta_d;
	node_t                 tgt_q, tgt_d;
	node_t                 w_q, w_d;
	logic [ID_W-1:0]       n_q, n_d;
	logic [ID_W-1:0]       c_q, c_d;
	logic [ID_W-1:0]       k_q, k_d;
	logic                  root_done_q, root_done_d;
	logic [ID_W-1:0]       lnk_addr_q, lnk_addr_d;
	lnk_fld_t              lnk_fld_q, lnk_fld_d;
	logic [ID_W-1:0]       lnk_val_q, lnk_val_d;
	state_t                lnk_ret_q, lnk_ret_d;
	logic [ID_W-1:0]       res_id_q, res_id_d;
	logic                  res_gr_q, res_gr_d;
	logic                  res_nl_q, res_nl_d;
	logic [ID_W-1:0]       new_id_q, new_id_d;
	logic                  granted_q, granted_d;
	logic                  all_nl_q, all_nl_d;

	// Memory ports
	logic                  nd_we;
	logic [IDX_W-1:0]      nd_wa, nd_ra;
	node_t                 nd_wd, nd_rd;
	logic [$bits(node_t)-1:0] nd_rd_raw;
	logic                  stk_we;
	logic [IDX_W-1:0]      stk_wa, stk_ra, stk_wd, stk_rd;
	logic [COUNT_BITS-1:0] rc_sum;
	logic [ID_W-1:0]       dm1;

	assign nd_rd = node_t'(nd_rd_raw);
	assign dm1   = depth_q - ID_W'(1);

	cap_ram #(
		.DEPTH(NODES),
		.WIDTH($bits(node_t))
	) u_pool (
		.clk  (clk),
		.we   (nd_we),
		.waddr(nd_wa),
		.wdata(nd_wd),
		.raddr(nd_ra),
		.rdata(nd_rd_raw)
	);

	cap_ram #(
		.DEPTH(NODES),
		.WIDTH(IDX_W)
	) u_stack (
		.clk  (clk),
		.we   (stk_we),
		.waddr(stk_wa),
		.wdata(stk_wd),
		.raddr(stk_ra),
		.rdata(stk_rd)
	);

	// Count unit: always fed from the freshly read record
	cap_sat_add #(
		.COUNT_BITS(COUNT_BITS)
	) u_add (
		.cnt  (nd_rd.rc),
		.delta(delta_q),
		.sum  (rc_sum)
	);

	assign in_ready       = (state_q == S_IDLE);
	assign out_valid      = out_valid_q;
	assign new_id         = new_id_q;
	assign granted        = granted_q;
	assign nonlinear_only = all_nl_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			free_q      <= NIL;
			bump_q      <= '0;
			depth_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q     <= state_d;
			free_q      <= free_d;
			bump_q      <= bump_d;
			depth_q     <= depth_d;
			out_valid_q <= out_valid_d;
		end
	end

	always_ff @(posedge clk) begin
		act_q       <= act_d;
		id_q        <= id_d;
		delta_q     <= delta_d;
		tgt_q       <= tgt_d;
		w_q         <= w_d;
		n_q         <= n_d;
		c_q         <= c_d;
		k_q         <= k_d;
		root_done_q <= root_done_d;
		lnk_addr_q  <= lnk_addr_d;
		lnk_fld_q   <= lnk_fld_d;
		lnk_val_q   <= lnk_val_d;
		lnk_ret_q   <= lnk_ret_d;
		res_id_q    <= res_id_d;
		res_gr_q    <= res_gr_d;
		res_nl_q    <= res_nl_d;
		new_id_q    <= new_id_d;
		granted_q   <= granted_d;
		all_nl_q    <= all_nl_d;
	end

	always_comb begin
		node_t           w;
		logic            has;
		logic [ID_W-1:0] prv_lnk;

		state_d     = state_q;
		free_d      = free_q;
		bump_d      = bump_q;
		depth_d     = depth_q;
		out_valid_d = out_valid_q && !out_ready;
		act_d       = act_q;
		id_d        = id_q;
		delta_d     = delta_q;
		tgt_d       = tgt_q;
		w_d         = w_q;
		n_d         = n_q;
		c_d         = c_q;
		k_d         = k_q;
		root_done_d = root_done_q;
		lnk_addr_d  = lnk_addr_q;
		lnk_fld_d   = lnk_fld_q;
		lnk_val_d   = lnk_val_q;
		lnk_ret_d   = lnk_ret_q;
		res_id_d    = res_id_q;
		res_gr_d    = res_gr_q;
		res_nl_d    = res_nl_q;
		new_id_d    = new_id_q;
		granted_d   = granted_q;
		all_nl_d    = all_nl_q;

		nd_we  = 1'b0;
		nd_wa  = id_q[IDX_W-1:0];
		nd_wd  = tgt_q;
		nd_ra  = id_q[IDX_W-1:0];
		stk_we = 1'b0;
		stk_wa = depth_q[IDX_W-1:0];
		stk_wd = c_q[IDX_W-1:0];
		stk_ra = dm1[IDX_W-1:0];

		w       = nd_rd;
		has     = (id_q < NIL);
		prv_lnk = (tgt_q.prv < NIL) ? tgt_q.prv : NIL;

		unique case (state_q)
			S_IDLE: begin
				// Read the target while the request is latched
				nd_ra = node_id[IDX_W-1:0];
				if (in_valid) begin
					act_d    = act_t'(action);
					id_d     = node_id;
					delta_d  = delta;
					res_id_d = NIL;
					res_gr_d = 1'b0;
					res_nl_d = 1'b0;
					state_d  = S_CHK;
				end
			end

			S_CHK: begin
				tgt_d   = nd_rd;
				state_d = S_DONE;
				unique case (act_q)
					ACT_ALLOC: begin
						if (!has || nd_rd.st == NS_VALID) state_d = S_TAKE;
					end
					ACT_SPLIT: begin
						if (has && nd_rd.st == NS_VALID) state_d = S_TAKE;
					end
					ACT_REFCNT: begin
						if (has && nd_rd.st != NS_FREE) begin
							w.rc = rc_sum;
							if (w.st == NS_INVALID && rc_sum == '0) begin
								w.st   = NS_FREE;
								w.nxt  = free_q;
								free_d = id_q;
							end
							nd_we = 1'b1;
							nd_wd = w;
						end
					end
					ACT_NONLIN: begin
						if (has && nd_rd.st != NS_FREE) begin
							w.nl  = 1'b1;
							nd_we = 1'b1;
							nd_wd = w;
						end
					end
					ACT_REVOKE: begin
						if (has && nd_rd.st == NS_VALID) begin
							depth_d     = '0;
							res_nl_d    = 1'b1;
							c_d         = nd_rd.fch;
							k_d         = '0;
							root_done_d = 1'b0;
							state_d     = S_RPUSH;
						end
					end
					ACT_DROP: begin
						if (has && nd_rd.st == NS_VALID) state_d = S_DROP0;
					end
					default: begin
						state_d = S_DONE;
					end
				endcase
			end

			S_TAKE: begin
				nd_ra = free_q[IDX_W-1:0];
				if (free_q < NIL) begin
					state_d = S_TAKE_W;
				end else if (bump_q < NIL) begin
					n_d     = bump_q;
					bump_d  = bump_q + ID_W'(1);
					state_d = S_NEW;
				end else begin
					state_d = S_DONE;
				end
			end

			S_TAKE_W: begin
				n_d     = free_q;
				free_d  = nd_rd.nxt;
				state_d = S_NEW;
			end

			S_NEW: begin
				w.st = NS_VALID;
				w.nl = 1'b0;
				w.rc = COUNT_BITS'(1);
				w.fch = NIL;
				if (act_q == ACT_ALLOC) begin
					w.par = has ? id_q : NIL;
					w.prv = NIL;
					w.nxt = has ? tgt_q.fch : NIL;
				end else begin
					w.par = tgt_q.par;
					w.prv = id_q;
					w.nxt = tgt_q.nxt;
				end
				nd_we    = 1'b1;
				nd_wa    = n_q[IDX_W-1:0];
				nd_wd    = w;
				res_id_d = n_q;
				res_gr_d = 1'b1;
				if (act_q != ACT_ALLOC) begin
					state_d = S_SID;
				end else if (!has) begin
					state_d = S_DONE;
				end else if (tgt_q.fch < NIL) begin
					lnk_addr_d = tgt_q.fch;
					lnk_fld_d  = LF_PRV;
					lnk_val_d  = n_q;
					lnk_ret_d  = S_AFCH;
					state_d    = S_LNK_RD;
				end else begin
					state_d = S_AFCH;
				end
			end

			S_AFCH: begin
				w       = tgt_q;
				w.fch   = n_q;
				nd_we   = 1'b1;
				nd_wd   = w;
				state_d = S_DONE;
			end

			S_SID: begin
				w       = tgt_q;
				w.nxt   = n_q;
				nd_we   = 1'b1;
				nd_wd   = w;
				state_d = S_DONE;
				// Repair the back link of the following sibling
				if (tgt_q.nxt < NIL) begin
					lnk_addr_d = tgt_q.nxt;
					lnk_fld_d  = LF_PRV;
					lnk_val_d  = n_q;
					lnk_ret_d  = S_DONE;
					state_d    = S_LNK_RD;
				end
			end

			S_LNK_RD: begin
				nd_ra   = lnk_addr_q[IDX_W-1:0];
				state_d = S_LNK_WR;
			end

			S_LNK_WR: begin
				case (lnk_fld_q)
					LF_PRV:  w.prv = lnk_val_q;
					LF_NXT:  w.nxt = lnk_val_q;
					default: w.fch = lnk_val_q;
				endcase
				nd_we   = 1'b1;
				nd_wa   = lnk_addr_q[IDX_W-1:0];
				nd_wd   = w;
				state_d = lnk_ret_q;
			end

			S_DROP0: begin
				// Point the predecessor (or the parent) at the children or at next
				lnk_val_d = (tgt_q.fch < NIL) ? tgt_q.fch : tgt_q.nxt;
				lnk_ret_d = (tgt_q.fch < NIL) ? S_DROP1 : S_DROPN;
				state_d   = (tgt_q.fch < NIL) ? S_DROP1 : S_DROPN;
				if (tgt_q.prv < NIL) begin
					lnk_addr_d = tgt_q.prv;
					lnk_fld_d  = LF_NXT;
					state_d    = S_LNK_RD;
				end else if (tgt_q.par < NIL) begin
					lnk_addr_d = tgt_q.par;
					lnk_fld_d  = LF_FCH;
					state_d    = S_LNK_RD;
				end
			end

			S_DROP1: begin
				c_d        = tgt_q.fch;
				k_d        = '0;
				lnk_addr_d = tgt_q.fch;
				lnk_fld_d  = LF_PRV;
				lnk_val_d  = prv_lnk;
				lnk_ret_d  = S_DWALK;
				state_d    = S_LNK_RD;
			end

			S_DWALK: begin
				nd_ra   = c_q[IDX_W-1:0];
				state_d = S_DWALK_W;
			end

			S_DWALK_W: begin
				// Advance to the last child
				if (k_q < NIL && nd_rd.nxt < NIL) begin
					c_d     = nd_rd.nxt;
					k_d     = k_q + ID_W'(1);
					state_d = S_DWALK;
				end else begin
					lnk_addr_d = c_q;
					lnk_fld_d  = LF_NXT;
					lnk_val_d  = tgt_q.nxt;
					lnk_ret_d  = S_DROP2;
					state_d    = S_LNK_RD;
				end
			end

			S_DROP2: begin
				state_d = S_FIN_RD;
				if (tgt_q.nxt < NIL) begin
					lnk_addr_d = tgt_q.nxt;
					lnk_fld_d  = LF_PRV;
					lnk_val_d  = c_q;
					lnk_ret_d  = S_FIN_RD;
					state_d    = S_LNK_RD;
				end
			end

			S_DROPN: begin
				state_d = S_FIN_RD;
				if (tgt_q.nxt < NIL) begin
					lnk_addr_d = tgt_q.nxt;
					lnk_fld_d  = LF_PRV;
					lnk_val_d  = prv_lnk;
					lnk_ret_d  = S_FIN_RD;
					state_d    = S_LNK_RD;
				end
			end

			S_FIN_RD: begin
				state_d = S_FIN_WR;
			end

			S_FIN_WR: begin
				w.st = NS_INVALID;
				if (nd_rd.rc == '0) begin
					w.st   = NS_FREE;
					w.nxt  = free_q;
					free_d = id_q;
				end
				nd_we   = 1'b1;
				nd_wd   = w;
				state_d = S_DONE;
			end

			S_RPUSH: begin
				nd_ra = c_q[IDX_W-1:0];
				if (k_q < NIL && c_q < NIL) begin
					// Drop the push when the stack is full
					if (depth_q < NIL) begin
						stk_we  = 1'b1;
						depth_d = depth_q + ID_W'(1);
					end
					state_d = S_RPUSH_W;
				end else begin
					root_done_d = 1'b1;
					state_d     = root_done_q ? S_RTF : S_RPOP;
				end
			end

			S_RPUSH_W: begin
				c_d     = nd_rd.nxt;
				k_d     = k_q + ID_W'(1);
				state_d = S_RPUSH;
			end

			S_RPOP: begin
				if (depth_q != '0) begin
					depth_d = dm1;
					state_d = S_RPOP_W;
				end else begin
					state_d = S_RFIN_RD;
				end
			end

			S_RPOP_W: begin
				nd_ra   = stk_rd;
				n_d     = ID_W'(stk_rd);
				state_d = S_RNODE;
			end

			S_RNODE: begin
				if (nd_rd.st != NS_VALID) begin
					state_d = S_RPOP;
				end else begin
					if (!nd_rd.nl) res_nl_d = 1'b0;
					w.st    = NS_INVALID;
					nd_we   = 1'b1;
					nd_wa   = n_q[IDX_W-1:0];
					nd_wd   = w;
					w_d     = w;
					c_d     = nd_rd.fch;
					k_d     = '0;
					state_d = S_RPUSH;
				end
			end

			S_RTF: begin
				if (w_q.rc == '0) begin
					w      = w_q;
					w.st   = NS_FREE;
					w.nxt  = free_q;
					nd_we  = 1'b1;
					nd_wa  = n_q[IDX_W-1:0];
					nd_wd  = w;
					free_d = n_q;
				end
				state_d = S_RPOP;
			end

			S_RFIN_RD: begin
				state_d = S_RFIN_WR;
			end

			S_RFIN_WR: begin
				w.fch   = NIL;
				nd_we   = 1'b1;
				nd_wd   = w;
				state_d = S_DONE;
			end

			S_DONE: begin
				// Hold until the output register is free
				if (!out_valid_q || out_ready) begin
					new_id_d    = res_id_q;
					granted_d   = res_gr_q;
					all_nl_d    = res_nl_q;
					out_valid_d = 1'b1;
					state_d     = S_IDLE;
				end
			end

			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	// Bump pointer never runs past the pool
	a_bump_range: assert property (@(posedge clk) disable iff (!arst_n)
		bump_q <= NIL)
		else $error("bump pointer beyond pool");

	// Free list head is a node or the null link
	a_free_range: assert property (@(posedge clk) disable iff (!arst_n)
		free_q <= NIL)
		else $error("free list head out of range");

	// A push into the walk stack only happens below capacity
	a_stack_push: assert property (@(posedge clk) disable iff (!arst_n)
		stk_we |-> (depth_q < NIL && state_q == S_RPUSH))
		else $error("walk stack overflow");

	// A new result is loaded only from the result state
	a_result_src: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_d && !out_valid_q) |=> $past(state_q) == S_DONE)
		else $error("result produced outside the result state");

endmodule
